FILE: src/bms_pkg.sv
`timescale 1ns / 1ps
package bms_pkg;

  localparam int ZW = 34;

  typedef struct packed {
    logic signed [ZW-1:0] x;
    logic signed [ZW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } bms_rot_t;

  localparam logic signed [ZW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 34'sd6746518852;
  localparam logic signed [ZW-1:0] Q30_GAIN    = 34'sd652032874;

  localparam logic [30:0] ATAN_Q30 [30] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1
  };

endpackage

FILE: src/bicycle_model_step_and_jacobian.sv
`timescale 1ns / 1ps
// Requests pass the front stages, angle reduction, CORDIC cells and back stages to done.
// Throughput: one request per cycle; busy stays low, set by the fully pipelined
// remainder and rotation cell chains, one cell per cycle.
// The receiver cannot stall; each result shows for one cycle with done high.
// Reset clears the pipeline valid bits and loads step_time with 6554.
module bicycle_model_step_and_jacobian #(
  parameter int FRAC_BITS       = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic signed [31:0] steer_angle,
  input  logic signed [31:0] steer_rate,
  input  logic signed [31:0] ref_speed,
  input  logic signed [31:0] curvature_factor,
  output logic               done,
  output logic signed [31:0] next_pos_x,
  output logic signed [31:0] next_pos_y,
  output logic signed [31:0] next_heading,
  output logic signed [31:0] next_steer,
  output logic signed [31:0] jac_x_heading,
  output logic signed [31:0] jac_x_steer,
  output logic signed [31:0] jac_y_heading,
  output logic signed [31:0] jac_y_steer,
  output logic signed [31:0] jac_heading_steer,
  output logic        [16:0] input_gain_steer,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic         [2:0] paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import bms_pkg::*;

  localparam int MW   = 62 - FRAC_BITS;
  localparam int NRED = 30 - FRAC_BITS;
  localparam int NIT  = TRIG_ITERATIONS;
  localparam int DLY  = NRED + NIT + 3;
  localparam int NV   = 11 + DLY;

  localparam logic REG_STEP_TIME = 1'b0;

  localparam logic signed [31:0] S_MAX   = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S_MIN   = 32'sh80000000;
  localparam logic signed [31:0] HALF    = 32'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] QUARTER = 32'sd1 <<< (FRAC_BITS - 2);
  localparam logic signed [31:0] SIXTH   = 32'((64'd1 << FRAC_BITS) + 64'd3) / 32'd6;
  localparam logic signed [31:0] THIRD   = 32'((64'd1 << FRAC_BITS) + 64'd1) / 32'd3;
  localparam logic [63:0]        RHALF   = 64'd1 << (FRAC_BITS - 1);
  localparam logic signed [ZW-1:0] TRND  = ZW'(1) << (29 - FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] dtv;
    logic signed [31:0] pk;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] th2;
    logic signed [31:0] r3;
    logic signed [31:0] r8;
    logic        [16:0] dt;
  } side_t;

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    logic        [63:0] m;
    logic        [63:0] r;
    p = 64'(a) * 64'(b);
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + RHALF) >> FRAC_BITS;
    if (!p[63]) begin
      return (r > 64'd2147483647) ? S_MAX : r[31:0];
    end
    return (r > 64'd2147483648) ? S_MIN : 32'(-r);
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) return S_MAX;
    if (s < -33'sd2147483648) return S_MIN;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] fx_neg(input logic signed [31:0] a);
    return (a == S_MIN) ? S_MAX : -a;
  endfunction

  function automatic logic signed [31:0] trig_out(input logic signed [ZW-1:0] v,
                                                  input logic flip);
    logic signed [ZW-1:0] f;
    logic signed [ZW-1:0] r;
    f = flip ? -v : v;
    r = (f + TRND) >>> (30 - FRAC_BITS);
    if (r > ZW'(S_MAX)) return S_MAX;
    if (r < ZW'(S_MIN)) return S_MIN;
    return r[31:0];
  endfunction

  // Configuration port.
  logic [16:0] step_time;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == REG_STEP_TIME) ? {15'b0, step_time} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= 17'd6554;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP_TIME) begin
      step_time <= pwdata[16:0];
    end
  end

  logic [NV-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NV-2:0], start};
    end
  end

  // Front arithmetic stages.
  logic signed [31:0] a_px, a_py, a_th, a_dl, a_om, a_v, a_k, a_dt;
  logic signed [31:0] b_dt2, b_dtv, b_kom, b_dlk, b_kv, b_dtom, b_dtk;
  logic signed [31:0] b_px, b_py, b_th, b_dl, b_v, b_dt;
  logic signed [31:0] c_komv, c_dlkv, c_kv2, c_r3, c_r8;
  logic signed [31:0] c_dt2, c_dtv, c_px, c_py, c_th, c_dt;
  logic signed [31:0] d_ta, d_tb, d_pk, d_dtv, d_px, d_py, d_th, d_dt, d_r3, d_r8;
  logic signed [31:0] e_tah, e_taq, e_tbh, e_tb;
  logic signed [31:0] e_dtv, e_px, e_py, e_th, e_dt, e_r3, e_r8, e_pk;
  logic signed [31:0] f_th0, f_th1, f_t2, f_t3;
  logic signed [31:0] f_dtv, f_px, f_py, f_dt, f_r3, f_r8, f_pk;
  logic signed [31:0] g_ang [4];
  side_t              side_dly [DLY+1];

  always_ff @(posedge clk) begin
    if (start) begin
      a_px <= pos_x;
      a_py <= pos_y;
      a_th <= heading;
      a_dl <= steer_angle;
      a_om <= steer_rate;
      a_v  <= ref_speed;
      a_k  <= curvature_factor;
      a_dt <= {15'b0, step_time};
    end

    b_dt2  <= fx_mul(a_dt, a_dt);
    b_dtv  <= fx_mul(a_dt, a_v);
    b_kom  <= fx_mul(a_k, a_om);
    b_dlk  <= fx_mul(a_dl, a_k);
    b_kv   <= fx_mul(a_k, a_v);
    b_dtom <= fx_mul(a_dt, a_om);
    b_dtk  <= fx_mul(a_dt, a_k);
    b_px   <= a_px;
    b_py   <= a_py;
    b_th   <= a_th;
    b_dl   <= a_dl;
    b_v    <= a_v;
    b_dt   <= a_dt;

    c_komv <= fx_mul(b_kom, b_v);
    c_dlkv <= fx_mul(b_dlk, b_v);
    c_kv2  <= fx_mul(b_kv, b_v);
    c_r3   <= fx_add(b_dl, b_dtom);
    c_r8   <= fx_mul(b_dtk, b_v);
    c_dt2  <= b_dt2;
    c_dtv  <= b_dtv;
    c_px   <= b_px;
    c_py   <= b_py;
    c_th   <= b_th;
    c_dt   <= b_dt;

    d_ta  <= fx_mul(c_komv, c_dt2);
    d_tb  <= fx_mul(c_dlkv, c_dt);
    d_pk  <= fx_mul(c_dt2, c_kv2);
    d_dtv <= c_dtv;
    d_px  <= c_px;
    d_py  <= c_py;
    d_th  <= c_th;
    d_dt  <= c_dt;
    d_r3  <= c_r3;
    d_r8  <= c_r8;

    e_tah <= fx_mul(d_ta, HALF);
    e_taq <= fx_mul(d_ta, QUARTER);
    e_tbh <= fx_mul(d_tb, HALF);
    e_tb  <= d_tb;
    e_dtv <= d_dtv;
    e_px  <= d_px;
    e_py  <= d_py;
    e_th  <= d_th;
    e_dt  <= d_dt;
    e_r3  <= d_r3;
    e_r8  <= d_r8;
    e_pk  <= d_pk;

    f_th0 <= e_th;
    f_th1 <= fx_add(e_th, e_tbh);
    f_t2  <= fx_add(e_tah, e_tb);
    f_t3  <= fx_add(e_taq, e_tbh);
    f_dtv <= e_dtv;
    f_px  <= e_px;
    f_py  <= e_py;
    f_dt  <= e_dt;
    f_r3  <= e_r3;
    f_r8  <= e_r8;
    f_pk  <= e_pk;

    g_ang[0] <= f_th0;
    g_ang[1] <= f_th1;
    g_ang[2] <= fx_add(f_t2, f_th0);
    g_ang[3] <= fx_add(f_t3, f_th0);
    side_dly[0].dtv <= f_dtv;
    side_dly[0].pk  <= f_pk;
    side_dly[0].px  <= f_px;
    side_dly[0].py  <= f_py;
    side_dly[0].th2 <= fx_add(f_t2, f_th0);
    side_dly[0].r3  <= f_r3;
    side_dly[0].r8  <= f_r8;
    side_dly[0].dt  <= f_dt[16:0];
    for (int i = 1; i <= DLY; i++) begin
      side_dly[i] <= side_dly[i-1];
    end
  end

  // Angle reduction and CORDIC lanes.
  logic [MW-1:0]      red_mag [4][NRED+1];
  logic               red_neg [4][NRED+1];
  bms_rot_t           rot     [4][NIT+1];
  logic signed [31:0] sn [4];
  logic signed [31:0] cs [4];

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [31:0]       ab;
    logic signed [ZW:0] zs;
    bms_rot_t          rot0;

    assign ab = g_ang[l][31] ? (~g_ang[l] + 32'd1) : g_ang[l];

    always_ff @(posedge clk) begin
      red_mag[l][0] <= MW'(ab) << (30 - FRAC_BITS);
      red_neg[l][0] <= g_ang[l][31];
    end

    for (genvar j = 0; j < NRED; j++) begin : g_red
      bms_redc_cell #(.MW(MW), .SH(NRED - 1 - j)) u_red (
        .clk     (clk),
        .din     (red_mag[l][j]),
        .din_neg (red_neg[l][j]),
        .dout    (red_mag[l][j+1]),
        .dout_neg(red_neg[l][j+1])
      );
    end

    always_comb begin
      zs = {1'b0, red_mag[l][NRED][ZW-1:0]};
      if (red_neg[l][NRED]) begin
        zs = -zs;
      end
      if (zs > (ZW+1)'(Q30_PI)) begin
        zs = zs - (ZW+1)'(Q30_TWO_PI);
      end else if (zs < -(ZW+1)'(Q30_PI)) begin
        zs = zs + (ZW+1)'(Q30_TWO_PI);
      end
      rot0.x    = Q30_GAIN;
      rot0.y    = '0;
      rot0.flip = 1'b0;
      if (zs > (ZW+1)'(Q30_HALF_PI)) begin
        zs = zs - (ZW+1)'(Q30_PI);
        rot0.flip = 1'b1;
      end else if (zs < -(ZW+1)'(Q30_HALF_PI)) begin
        zs = zs + (ZW+1)'(Q30_PI);
        rot0.flip = 1'b1;
      end
      rot0.z = zs[ZW-1:0];
    end

    always_ff @(posedge clk) begin
      rot[l][0] <= rot0;
    end

    for (genvar i = 0; i < NIT; i++) begin : g_rot
      bms_cordic_cell #(.IDX(i)) u_rot (
        .clk (clk),
        .din (rot[l][i]),
        .dout(rot[l][i+1])
      );
    end

    always_ff @(posedge clk) begin
      cs[l] <= trig_out(rot[l][NIT].x, rot[l][NIT].flip);
      sn[l] <= trig_out(rot[l][NIT].y, rot[l][NIT].flip);
    end
  end

  // Back arithmetic stages.
  side_t              t1_sd, t2_sd, t3_sd;
  logic signed [31:0] t1_mc [4];
  logic signed [31:0] t1_ms [4];
  logic signed [31:0] t1_pc, t1_ps;
  logic signed [31:0] t2_wc [4];
  logic signed [31:0] t2_ws [4];
  logic signed [31:0] t2_r4, t2_r6, t2_r5a, t2_r7;
  logic signed [31:0] t3_nx, t3_ny, t3_wc2, t3_wc3, t3_ws2, t3_ws3;
  logic signed [31:0] t3_r4, t3_r5, t3_r6, t3_r7;

  always_ff @(posedge clk) begin
    t1_sd <= side_dly[DLY];
    for (int i = 0; i < 4; i++) begin
      t1_mc[i] <= fx_mul(side_dly[DLY].dtv, cs[i]);
      t1_ms[i] <= fx_mul(side_dly[DLY].dtv, sn[i]);
    end
    t1_pc <= fx_mul(side_dly[DLY].pk, cs[0]);
    t1_ps <= fx_mul(side_dly[DLY].pk, sn[0]);

    t2_sd <= t1_sd;
    for (int i = 0; i < 4; i++) begin
      t2_wc[i] <= fx_mul(t1_mc[i], i[0] ? THIRD : SIXTH);
      t2_ws[i] <= fx_mul(t1_ms[i], i[0] ? THIRD : SIXTH);
    end
    t2_r4  <= fx_neg(t1_ms[0]);
    t2_r6  <= t1_mc[0];
    t2_r5a <= fx_mul(t1_ps, HALF);
    t2_r7  <= fx_mul(t1_pc, HALF);

    t3_sd  <= t2_sd;
    t3_nx  <= fx_add(fx_add(t2_sd.px, t2_wc[0]), t2_wc[1]);
    t3_ny  <= fx_add(fx_add(t2_sd.py, t2_ws[0]), t2_ws[1]);
    t3_wc2 <= t2_wc[2];
    t3_wc3 <= t2_wc[3];
    t3_ws2 <= t2_ws[2];
    t3_ws3 <= t2_ws[3];
    t3_r4  <= t2_r4;
    t3_r5  <= fx_neg(t2_r5a);
    t3_r6  <= t2_r6;
    t3_r7  <= t2_r7;

    next_pos_x        <= fx_add(fx_add(t3_nx, t3_wc2), t3_wc3);
    next_pos_y        <= fx_add(fx_add(t3_ny, t3_ws2), t3_ws3);
    next_heading      <= t3_sd.th2;
    next_steer        <= t3_sd.r3;
    jac_x_heading     <= t3_r4;
    jac_x_steer       <= t3_r5;
    jac_y_heading     <= t3_r6;
    jac_y_steer       <= t3_r7;
    jac_heading_steer <= t3_sd.r8;
    input_gain_steer  <= t3_sd.dt;
  end

  assign done = vld[NV-1];

endmodule

FILE: src/bms_redc_cell.sv
`timescale 1ns / 1ps
module bms_redc_cell #(
  parameter int MW = 46,
  parameter int SH = 0
) (
  input  logic          clk,
  input  logic [MW-1:0] din,
  input  logic          din_neg,
  output logic [MW-1:0] dout,
  output logic          dout_neg
);
  import bms_pkg::*;

  localparam logic [MW-1:0] STEP = MW'(Q30_TWO_PI) << SH;

  always_ff @(posedge clk) begin
    if (din >= STEP) begin
      dout <= din - STEP;
    end else begin
      dout <= din;
    end
    dout_neg <= din_neg;
  end

endmodule

FILE: src/bms_cordic_cell.sv
`timescale 1ns / 1ps
module bms_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  bms_pkg::bms_rot_t din,
  output bms_pkg::bms_rot_t dout
);
  import bms_pkg::*;

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q30[IDX]);

  bms_rot_t nxt;

  always_comb begin
    nxt = din;
    if (din.z >= 0) begin
      nxt.x = din.x - (din.y >>> IDX);
      nxt.y = din.y + (din.x >>> IDX);
      nxt.z = din.z - ANG;
    end else begin
      nxt.x = din.x + (din.y >>> IDX);
      nxt.y = din.y - (din.x >>> IDX);
      nxt.z = din.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule
